>>> rtl/irlf_pkg.sv
// Package for the identifier remap allocator: sizes, kind and status codes.
// No dependencies.
package irlf_pkg;
    localparam int SLOTS_DEF = 1024;
    localparam int ORIGINAL_WIDTH_DEF = 32;
    localparam int COMPACT_W = 10;
    localparam int COUNT_W = 11;
    localparam int ID_IN_W = 32;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    typedef struct packed {
        logic [COMPACT_W-1:0] compact_index;
        logic [1:0]           status;
        logic [COUNT_W-1:0]   issued_count;
    } result_t;
endpackage

>>> rtl/irlf_table.sv
// Slot table: in-use bits and identifier memory, one synchronous read port.
// Entries at or above the fill count read as free. Depends on irlf_pkg.
module irlf_table
    import irlf_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int ORIGINAL_WIDTH = ORIGINAL_WIDTH_DEF,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [CW-1:0]             fill_count,
    input  logic [AW-1:0]             rd_addr,
    output logic                      rd_used,
    output logic [ORIGINAL_WIDTH-1:0] rd_id,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic                      wr_used,
    input  logic [ORIGINAL_WIDTH-1:0] wr_id
);
    logic [ORIGINAL_WIDTH-1:0] id_mem [SLOTS];
    logic                      used_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]   <= wr_id;
            used_mem[wr_addr] <= wr_used;
        end
        rd_id <= id_mem[rd_addr];
    end

    // Entries at or above the fill count were never written: read them as free.
    logic rd_ok_reg, rd_raw_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_ok_reg <= 1'b0;
        else
            rd_ok_reg <= (CW'(rd_addr) < fill_count);
    end

    always_ff @(posedge clk)
    begin
        rd_raw_reg <= used_mem[rd_addr];
    end

    assign rd_used = rd_ok_reg & rd_raw_reg;
endmodule

>>> rtl/index_remap_lowest_free_allocator_core.sv
// Channel | dir | tdata fields (low bit up)                 | tuser
// s_axis  | in  | original_index[31:0]                      | kind[1:0]
// m_axis  | out | compact_index[9:0], status[11:10],        | -
//         |     | issued_count[22:12], zero fill to 24 bits |
// One transaction scans all SLOTS table entries through one memory read port: the
// result is registered on completion, and the next input is accepted only after that
// result has been taken, so a new transaction never starts before the last is through.
// Reset clears the issued count; entries at or above it read as free, no clearing pass.
// The result waits in an output register; input stalls for as long as it waits.
// Depends on irlf_pkg and irlf_table.
module index_remap_lowest_free_allocator_core
    import irlf_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int ORIGINAL_WIDTH = ORIGINAL_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // original_index
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // compact_index, status, issued_count
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t                    state_reg;
    logic [1:0]                kind_reg;
    logic [ORIGINAL_WIDTH-1:0] id_reg;
    logic [CW-1:0]             addr_reg;
    logic [AW-1:0]             rd_slot_reg;
    logic                      rd_pend_reg;
    logic                      found_reg, free_reg;
    logic [AW-1:0]             found_slot_reg, free_slot_reg;
    logic [CW-1:0]             issued_reg;
    result_t                   res_reg;
    logic                      out_valid_reg;

    result_t                   res_next;
    logic [CW-1:0]             issued_next;

    logic                      rd_used;
    logic [ORIGINAL_WIDTH-1:0] rd_id;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic                      wr_used;
    logic                      hit;
    logic [ORIGINAL_WIDTH-1:0] in_id;

    assign in_id = ORIGINAL_WIDTH'({{(ORIGINAL_WIDTH > ID_IN_W ? ORIGINAL_WIDTH-ID_IN_W : 1){1'b0}},
                                    s_axis_tdata});

    irlf_table #(.SLOTS(SLOTS), .ORIGINAL_WIDTH(ORIGINAL_WIDTH)) u_table (
        .clk(clk), .rst_n(rst_n), .fill_count(issued_reg),
        .rd_addr(addr_reg[AW-1:0]), .rd_used(rd_used), .rd_id(rd_id),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_used(wr_used), .wr_id(id_reg)
    );

    assign hit = rd_pend_reg && rd_used && (rd_id == id_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = found_slot_reg;
        wr_used = 1'b0;
        if (state_reg == S_DONE)
        begin
            if (kind_reg == KIND_ALLOC && !found_reg && free_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = free_slot_reg;
                wr_used = 1'b1;
            end
            else if (kind_reg == KIND_RELEASE && found_reg)
                wr_en = 1'b1;
        end
    end

    always_comb
    begin
        res_next.compact_index = '0;
        res_next.status        = ST_OK;
        issued_next            = issued_reg;
        if (kind_reg == KIND_ALLOC)
        begin
            if (found_reg)
                res_next.status = ST_DUPLICATE;
            else if (!free_reg)
                res_next.status = ST_FULL;
            else
            begin
                res_next.compact_index = COMPACT_W'(free_slot_reg);
                if (CW'(free_slot_reg) == issued_reg)
                    issued_next = issued_reg + CW'(1);
            end
        end
        else if (found_reg)
            res_next.compact_index = COMPACT_W'(found_slot_reg);
        else
            res_next.status = ST_NOT_FOUND;
        res_next.issued_count = COUNT_W'(issued_next);
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.issued_count, res_reg.status, res_reg.compact_index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            issued_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            addr_reg       <= '0;
            kind_reg       <= KIND_ALLOC;
            id_reg         <= '0;
            rd_slot_reg    <= '0;
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            found_slot_reg <= '0;
            free_slot_reg  <= '0;
            res_reg        <= '0;
        end
        else
        begin
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        kind_reg    <= s_axis_tuser;
                        id_reg      <= in_id;
                        addr_reg    <= '0;
                        rd_pend_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        free_reg    <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (rd_pend_reg)
                    begin
                        if (hit && !found_reg)
                        begin
                            found_reg      <= 1'b1;
                            found_slot_reg <= rd_slot_reg;
                        end
                        if (!rd_used && !free_reg)
                        begin
                            free_reg      <= 1'b1;
                            free_slot_reg <= rd_slot_reg;
                        end
                    end
                    rd_slot_reg <= addr_reg[AW-1:0];
                    if (addr_reg == CW'(SLOTS))
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        addr_reg    <= addr_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    res_reg    <= res_next;
                    issued_reg <= issued_next;
                    addr_reg   <= '0;
                    state_reg  <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input accepted during scan");
    a_issued_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg <= CW'(SLOTS))
        else $error("issued count beyond slot count");
    a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid_reg)
        else $error("result not presented");
    a_write_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_DONE))
        else $error("table write outside completion");
endmodule
